>>> rtl/core/euler_trs_model_matrix_assert.svh
// Assertion macros for the model matrix block.
`ifndef EULER_TRS_MODEL_MATRIX_ASSERT_SVH
`define EULER_TRS_MODEL_MATRIX_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ETM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ETM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/etm_pkg.sv
// Shared types, constants and arithmetic helpers of the model matrix block.
package etm_pkg;

  localparam int unsigned FracBits    = 16;
  localparam logic [31:0] OneQ        = 32'd1 << FracBits;
  localparam int unsigned HornerSteps = 8;
  localparam logic [30:0] Q30One      = 31'h4000_0000;
  localparam logic [30:0] HalfPiQ30   = 31'd1686629713;

  // Divisors of the sine and cosine series, innermost Horner term first.
  localparam int unsigned SinDiv [HornerSteps] = '{272, 210, 156, 110, 72, 42, 20, 6};
  localparam int unsigned CosDiv [HornerSteps] = '{306, 240, 182, 132, 90, 56, 30, 12};

  localparam int unsigned FrontLat = 2;
  localparam int unsigned StepLat  = 3;
  localparam int unsigned BackLat  = 2;
  localparam int unsigned ScLat    = FrontLat + HornerSteps * StepLat + BackLat;
  localparam int unsigned MxLat    = 6;
  localparam int unsigned PipeLat  = ScLat + MxLat;

  localparam logic [1:0] QuadI   = 2'd0;
  localparam logic [1:0] QuadII  = 2'd1;
  localparam logic [1:0] QuadIII = 2'd2;
  localparam logic [1:0] QuadIV  = 2'd3;

  localparam logic [1:0] Row0 = 2'd0;
  localparam logic [1:0] Row1 = 2'd1;
  localparam logic [1:0] Row2 = 2'd2;
  localparam logic [1:0] Row3 = 2'd3;

  typedef struct packed {
    logic [30:0] x;
    logic [31:0] x2;
    logic [30:0] s;
    logic [30:0] c;
    logic [1:0]  quad;
  } horner_t;

  typedef logic [2:0][2:0][31:0] mat_t;
  typedef logic [2:0][31:0]      pos_t;

  // Shift right by 30 with rounding half away from zero.
  function automatic logic signed [65:0] rnd30(input logic signed [65:0] v);
    logic [65:0] mag;
    logic [65:0] rnd;
    mag = v[65] ? 66'(-v) : 66'(v);
    rnd = (mag + (66'd1 << 29)) >> 30;
    rnd30 = v[65] ? -$signed(rnd) : $signed(rnd);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      sat32 = 32'h7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

>>> rtl/core/etm_in_if.sv
// Input channel of the model matrix block: one object per beat.
interface etm_in_if #(parameter int unsigned ANGLE_BITS = 16) ();
  logic                  valid;
  logic                  ready;
  logic signed [31:0]    pos_x;
  logic signed [31:0]    pos_y;
  logic signed [31:0]    pos_z;
  logic [ANGLE_BITS-1:0] angle_x;
  logic [ANGLE_BITS-1:0] angle_y;
  logic [ANGLE_BITS-1:0] angle_z;
  logic signed [31:0]    scale_factor;

  modport source (output valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                  scale_factor, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                scale_factor, output ready);
endinterface

>>> rtl/core/etm_out_if.sv
// Output channel of the model matrix block: one matrix row per beat.
interface etm_out_if ();
  logic              valid;
  logic              ready;
  logic [1:0]        row_index;
  logic signed [31:0] col0;
  logic signed [31:0] col1;
  logic signed [31:0] col2;
  logic signed [31:0] col3;
  logic              last_row;

  modport source (output valid, row_index, col0, col1, col2, col3, last_row, input ready);
  modport sink (input valid, row_index, col0, col1, col2, col3, last_row, output ready);
endinterface

>>> rtl/core/etm_horner_step.sv
// One Horner step of the sine and cosine series, with exact division by a constant.
module etm_horner_step #(
  parameter int unsigned SinDivisor = 6,
  parameter int unsigned CosDivisor = 12
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  etm_pkg::horner_t step_i,
  output etm_pkg::horner_t step_o
);
  import etm_pkg::*;

  localparam logic [31:0] SinRecip = 32'((64'd1 << 32) / SinDivisor);
  localparam logic [31:0] CosRecip = 32'((64'd1 << 32) / CosDivisor);

  horner_t     st1_q, st2_q, st3_q, st3_d;
  logic [62:0] ps1_q, pc1_q;
  logic [31:0] vs2_q, vc2_q;
  logic [63:0] qs2_q, qc2_q;
  logic [31:0] qs0, qc0;
  logic [39:0] rs, rc;
  logic [31:0] qs, qc;

  // The reciprocal is rounded down, so the estimate is at most one short.
  always_comb begin
    qs0   = qs2_q[63:32];
    qc0   = qc2_q[63:32];
    rs    = 40'(vs2_q) - 40'(qs0) * 40'(SinDivisor);
    rc    = 40'(vc2_q) - 40'(qc0) * 40'(CosDivisor);
    qs    = (rs >= 40'(SinDivisor)) ? qs0 + 32'd1 : qs0;
    qc    = (rc >= 40'(CosDivisor)) ? qc0 + 32'd1 : qc0;
    st3_d   = st2_q;
    st3_d.s = Q30One - 31'(qs);
    st3_d.c = Q30One - 31'(qc);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st1_q <= step_i;
      ps1_q <= 63'(step_i.x2) * 63'(step_i.s);
      pc1_q <= 63'(step_i.x2) * 63'(step_i.c);
      st2_q <= st1_q;
      vs2_q <= ps1_q[61:30];
      vc2_q <= pc1_q[61:30];
      qs2_q <= 64'(ps1_q[61:30]) * 64'(SinRecip);
      qc2_q <= 64'(pc1_q[61:30]) * 64'(CosRecip);
      st3_q <= st3_d;
    end
  end

  assign step_o = st3_q;

endmodule

>>> rtl/core/etm_sincos.sv
// Pipelined sine and cosine of one turn-fraction angle in signed Q30.
module etm_sincos #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [ANGLE_BITS-1:0] angle_i,
  output logic signed [31:0]    sin_o,
  output logic signed [31:0]    cos_o
);
  import etm_pkg::*;

  logic [29:0] frac;
  logic [60:0] xa;
  logic [61:0] sq;
  logic [30:0] xa_q;
  logic [1:0]  qa_q;
  horner_t     chain [HornerSteps+1];
  horner_t     h0_q;
  logic [61:0] sp_q;
  logic [62:0] cp_q;
  logic [1:0]  qf_q;
  logic [31:0] sv;
  logic [31:0] vc;
  logic signed [32:0] cv;
  logic [30:0] svc, cvc;
  logic signed [31:0] sin_d, cos_d, sin_q, cos_q;

  assign frac = {angle_i[ANGLE_BITS-3:0], {(32 - ANGLE_BITS){1'b0}}};
  assign xa   = 61'(frac) * 61'(HalfPiQ30) + (61'd1 << 29);
  assign sq   = 62'(xa_q) * 62'(xa_q) + (62'd1 << 29);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xa_q      <= xa[60:30];
      qa_q      <= angle_i[ANGLE_BITS-1 -: 2];
      h0_q.x    <= xa_q;
      h0_q.x2   <= sq[61:30];
      h0_q.s    <= Q30One;
      h0_q.c    <= Q30One;
      h0_q.quad <= qa_q;
    end
  end

  assign chain[0] = h0_q;

  for (genvar j = 0; j < HornerSteps; j++) begin : g_step
    etm_horner_step #(
      .SinDivisor(SinDiv[j]),
      .CosDivisor(CosDiv[j])
    ) u_step (
      .clk_i (clk_i),
      .en_i  (en_i),
      .step_i(chain[j]),
      .step_o(chain[j+1])
    );
  end

  always_comb begin
    sv  = sp_q[61:30];
    svc = (sv > 32'(Q30One)) ? Q30One : sv[30:0];
    vc  = cp_q[61:30];
    cv  = $signed(33'(Q30One)) - $signed(33'(vc >> 1));
    if (cv < 33'sd0) begin
      cvc = '0;
    end else if (cv > $signed(33'(Q30One))) begin
      cvc = Q30One;
    end else begin
      cvc = cv[30:0];
    end
    case (qf_q)
      QuadI: begin
        sin_d = $signed(32'(svc));
        cos_d = $signed(32'(cvc));
      end
      QuadII: begin
        sin_d = $signed(32'(cvc));
        cos_d = -$signed(32'(svc));
      end
      QuadIII: begin
        sin_d = -$signed(32'(svc));
        cos_d = -$signed(32'(cvc));
      end
      default: begin
        sin_d = -$signed(32'(cvc));
        cos_d = $signed(32'(svc));
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sp_q  <= 62'(chain[HornerSteps].x) * 62'(chain[HornerSteps].s);
      cp_q  <= 63'(chain[HornerSteps].x2) * 63'(chain[HornerSteps].c);
      qf_q  <= chain[HornerSteps].quad;
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

>>> rtl/core/etm_matrix.sv
// Pipelined rotation product, scaling and saturation of the 3x3 block.
module etm_matrix (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] sx_i,
  input  logic signed [31:0] cx_i,
  input  logic signed [31:0] sy_i,
  input  logic signed [31:0] cy_i,
  input  logic signed [31:0] sz_i,
  input  logic signed [31:0] cz_i,
  input  logic signed [31:0] scale_i,
  output etm_pkg::mat_t      mat_o
);
  import etm_pkg::*;

  // First products of sine and cosine pairs.
  logic signed [63:0] p_cycz_q, p_cysz_q, p_cxcz_q, p_sxsz_q, p_sxcz_q;
  logic signed [63:0] p_sxcy_q, p_cxcy_q, p_cxsz_q, p_sxsy_q, p_cxsy_q;
  logic signed [31:0] sy1_q, sz1_q, cz1_q, sc1_q;
  // Rounded first products.
  logic signed [31:0] r_cycz_q, r_cysz_q, r_cxcz_q, r_sxsz_q, r_sxcz_q;
  logic signed [31:0] r_sxcy_q, r_cxcy_q, r_cxsz_q, r_sxsy_q, r_cxsy_q;
  logic signed [31:0] sy2_q, sz2_q, cz2_q, sc2_q;
  // Second products and the entries that pass alongside.
  logic signed [63:0] q_sxsycz_q, q_sxsysz_q, q_cxsycz_q, q_cxsysz_q;
  logic signed [31:0] t_cycz_q, t_cysz_q, t_cxcz_q, t_sxsz_q, t_sxcz_q;
  logic signed [31:0] t_sxcy_q, t_cxcy_q, t_cxsz_q, sy3_q, sc3_q;
  logic signed [32:0] ent_d [3][3];
  logic signed [32:0] ent_q [3][3];
  logic signed [31:0] sc4_q;
  logic signed [65:0] prod_q [3][3];
  mat_t               mat_d, mat_q;
  logic signed [31:0] a_sxsycz, a_sxsysz, a_cxsycz, a_cxsysz;

  always_comb begin
    a_sxsycz = 32'(rnd30(66'(q_sxsycz_q)));
    a_sxsysz = 32'(rnd30(66'(q_sxsysz_q)));
    a_cxsycz = 32'(rnd30(66'(q_cxsycz_q)));
    a_cxsysz = 32'(rnd30(66'(q_cxsysz_q)));
    ent_d[0][0] = 33'(t_cycz_q);
    ent_d[0][1] = -33'(t_cysz_q);
    ent_d[0][2] = 33'(sy3_q);
    ent_d[1][0] = 33'(a_sxsycz) + 33'(t_cxsz_q);
    ent_d[1][1] = 33'(t_cxcz_q) - 33'(a_sxsysz);
    ent_d[1][2] = -33'(t_sxcy_q);
    ent_d[2][0] = 33'(t_sxsz_q) - 33'(a_cxsycz);
    ent_d[2][1] = 33'(a_cxsysz) + 33'(t_sxcz_q);
    ent_d[2][2] = 33'(t_cxcy_q);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mat_d[i][j] = sat32(rnd30(prod_q[i][j]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_cycz_q <= 64'(cy_i) * 64'(cz_i);
      p_cysz_q <= 64'(cy_i) * 64'(sz_i);
      p_cxcz_q <= 64'(cx_i) * 64'(cz_i);
      p_sxsz_q <= 64'(sx_i) * 64'(sz_i);
      p_sxcz_q <= 64'(sx_i) * 64'(cz_i);
      p_sxcy_q <= 64'(sx_i) * 64'(cy_i);
      p_cxcy_q <= 64'(cx_i) * 64'(cy_i);
      p_cxsz_q <= 64'(cx_i) * 64'(sz_i);
      p_sxsy_q <= 64'(sx_i) * 64'(sy_i);
      p_cxsy_q <= 64'(cx_i) * 64'(sy_i);
      sy1_q    <= sy_i;
      sz1_q    <= sz_i;
      cz1_q    <= cz_i;
      sc1_q    <= scale_i;

      r_cycz_q <= 32'(rnd30(66'(p_cycz_q)));
      r_cysz_q <= 32'(rnd30(66'(p_cysz_q)));
      r_cxcz_q <= 32'(rnd30(66'(p_cxcz_q)));
      r_sxsz_q <= 32'(rnd30(66'(p_sxsz_q)));
      r_sxcz_q <= 32'(rnd30(66'(p_sxcz_q)));
      r_sxcy_q <= 32'(rnd30(66'(p_sxcy_q)));
      r_cxcy_q <= 32'(rnd30(66'(p_cxcy_q)));
      r_cxsz_q <= 32'(rnd30(66'(p_cxsz_q)));
      r_sxsy_q <= 32'(rnd30(66'(p_sxsy_q)));
      r_cxsy_q <= 32'(rnd30(66'(p_cxsy_q)));
      sy2_q    <= sy1_q;
      sz2_q    <= sz1_q;
      cz2_q    <= cz1_q;
      sc2_q    <= sc1_q;

      q_sxsycz_q <= 64'(r_sxsy_q) * 64'(cz2_q);
      q_sxsysz_q <= 64'(r_sxsy_q) * 64'(sz2_q);
      q_cxsycz_q <= 64'(r_cxsy_q) * 64'(cz2_q);
      q_cxsysz_q <= 64'(r_cxsy_q) * 64'(sz2_q);
      t_cycz_q   <= r_cycz_q;
      t_cysz_q   <= r_cysz_q;
      t_cxcz_q   <= r_cxcz_q;
      t_sxsz_q   <= r_sxsz_q;
      t_sxcz_q   <= r_sxcz_q;
      t_sxcy_q   <= r_sxcy_q;
      t_cxcy_q   <= r_cxcy_q;
      t_cxsz_q   <= r_cxsz_q;
      sy3_q      <= sy2_q;
      sc3_q      <= sc2_q;

      ent_q <= ent_d;
      sc4_q <= sc3_q;

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= 66'(ent_q[i][j]) * 66'(sc4_q);
        end
      end

      mat_q <= mat_d;
    end
  end

  assign mat_o = mat_q;

endmodule

>>> rtl/core/euler_trs_model_matrix.sv
// Model matrix builder: each accepted object (position, three turn-fraction
// Euler angles, uniform scale) yields the four rows of T*Rx*Ry*Rz*S, row 0
// first, with last_row set on row 3. Sine and cosine come from a series
// evaluated in a pipeline of eight Horner steps per angle, followed by six
// stages of rotation products, scaling and saturation. A new object can enter
// every cycle while the pipeline drains, but each object occupies the output
// for four beats, so the sustained rate is set by the row serializer at the
// output. The input stalls only while the last pipeline stage holds an object
// and the serializer is busy.
`include "euler_trs_model_matrix_assert.svh"

module euler_trs_model_matrix #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  etm_in_if.sink     in_i,
  etm_out_if.source  res_o
);
  import etm_pkg::*;

  logic [PipeLat-1:0] vld_q;
  pos_t               pos_q [PipeLat];
  logic signed [31:0] scl_q [ScLat];
  logic               adv;
  logic               tail_vld;
  logic               ser_free;
  logic               load;
  logic signed [31:0] sx, cx, sy, cy, sz, cz;
  mat_t               mat;
  logic               busy_q;
  logic [1:0]         row_q;
  mat_t               hold_mat_q;
  pos_t               hold_pos_q;

  assign tail_vld = vld_q[PipeLat-1];
  assign ser_free = !busy_q || (res_o.ready && row_q == Row3);
  assign adv      = !tail_vld || ser_free;
  assign load     = adv && tail_vld;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PipeLat-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_q[0] <= {in_i.pos_z, in_i.pos_y, in_i.pos_x};
      scl_q[0] <= in_i.scale_factor;
      for (int i = 1; i < PipeLat; i++) begin
        pos_q[i] <= pos_q[i-1];
      end
      for (int i = 1; i < ScLat; i++) begin
        scl_q[i] <= scl_q[i-1];
      end
    end
  end

  etm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_x (
    .clk_i  (clk_i),
    .en_i   (adv),
    .angle_i(in_i.angle_x),
    .sin_o  (sx),
    .cos_o  (cx)
  );

  etm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_y (
    .clk_i  (clk_i),
    .en_i   (adv),
    .angle_i(in_i.angle_y),
    .sin_o  (sy),
    .cos_o  (cy)
  );

  etm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_z (
    .clk_i  (clk_i),
    .en_i   (adv),
    .angle_i(in_i.angle_z),
    .sin_o  (sz),
    .cos_o  (cz)
  );

  etm_matrix u_matrix (
    .clk_i  (clk_i),
    .en_i   (adv),
    .sx_i   (sx),
    .cx_i   (cx),
    .sy_i   (sy),
    .cy_i   (cy),
    .sz_i   (sz),
    .cz_i   (cz),
    .scale_i(scl_q[ScLat-1]),
    .mat_o  (mat)
  );

  // Row serializer: holds one finished matrix and hands out one row per beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= Row0;
    end else if (load) begin
      busy_q <= 1'b1;
      row_q  <= Row0;
    end else if (busy_q && res_o.ready) begin
      if (row_q == Row3) begin
        busy_q <= 1'b0;
      end else begin
        row_q <= row_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      hold_mat_q <= mat;
      hold_pos_q <= pos_q[PipeLat-1];
    end
  end

  assign res_o.valid     = busy_q;
  assign res_o.row_index = row_q;
  assign res_o.last_row  = (row_q == Row3);

  always_comb begin
    case (row_q)
      Row0: begin
        res_o.col0 = hold_mat_q[0][0];
        res_o.col1 = hold_mat_q[0][1];
        res_o.col2 = hold_mat_q[0][2];
        res_o.col3 = hold_pos_q[0];
      end
      Row1: begin
        res_o.col0 = hold_mat_q[1][0];
        res_o.col1 = hold_mat_q[1][1];
        res_o.col2 = hold_mat_q[1][2];
        res_o.col3 = hold_pos_q[1];
      end
      Row2: begin
        res_o.col0 = hold_mat_q[2][0];
        res_o.col1 = hold_mat_q[2][1];
        res_o.col2 = hold_mat_q[2][2];
        res_o.col3 = hold_pos_q[2];
      end
      default: begin
        res_o.col0 = '0;
        res_o.col1 = '0;
        res_o.col2 = '0;
        res_o.col3 = OneQ;
      end
    endcase
  end

  `ETM_ASSERT_NEXT(a_row_step, busy_q && res_o.ready && row_q != Row3, busy_q && row_q == 2'($past(row_q) + 2'd1), "row did not advance after a beat")
  `ETM_ASSERT_NEXT(a_reload, busy_q && res_o.ready && row_q == Row3 && tail_vld, busy_q && row_q == Row0, "waiting matrix not loaded after last row")
  `ETM_ASSERT_NEXT(a_stall_hold, !adv, $stable(vld_q), "pipeline moved while stalled")
  `ETM_ASSERT_NOW(a_idle_ready, tail_vld && !busy_q, in_i.ready, "pipeline stalled with idle serializer")

endmodule
